// ----- design/u8u16_pkg.sv -----
package u8u16_pkg;

    // default number of jobs between decoder and unit emitter
    localparam int QUEUE_DEPTH = 4;

    // replacement character for bad input
    localparam logic [15:0] REPL_UNIT = 16'hFFFD;

    // one input beat
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_beat;

    // one output beat
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } t_out_beat;

    // work for one accepted byte: replacements first, then up to two decoded units
    typedef struct packed {
        logic [2:0]  repl_count;
        logic [1:0]  tail_count;
        logic [15:0] tail_first;
        logic [15:0] tail_second;
        logic        last;
    } t_job;

    // job queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- design/u8u16_front.sv -----
module u8u16_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  u8u16_pkg::t_in_beat  i_data,
    input  u8u16_pkg::t_q_status i_q_status,
    output logic                 o_push,
    output u8u16_pkg::t_job      o_job
);
    import u8u16_pkg::*;

    localparam logic [7:0]  CONT_MASK    = 8'hC0;
    localparam logic [7:0]  CONT_TAG     = 8'h80;
    localparam logic [7:0]  LEAD2_MASK   = 8'hE0;
    localparam logic [7:0]  LEAD2_TAG    = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK   = 8'hF0;
    localparam logic [7:0]  LEAD3_TAG    = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK   = 8'hF8;
    localparam logic [7:0]  LEAD4_TAG    = 8'hF0;
    localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
    localparam logic [10:0] MIN_2BYTE    = 11'h080;
    localparam logic [15:0] MIN_3BYTE    = 16'h0800;
    localparam logic [15:0] SURR_FIRST   = 16'hD800;
    localparam logic [15:0] SURR_LAST    = 16'hDFFF;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;

    // sequence length announced by a lead byte, zero when not a lead
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & LEAD2_MASK) == LEAD2_TAG) len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_TAG) len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_TAG) len = 3'd4;
        return len;
    endfunction

    logic [23:0] r_held_bytes, n_held_bytes;
    logic [1:0]  r_held_count, n_held_count;
    logic        w_accept;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_cont;
    logic [2:0]  w_need;
    logic [2:0]  w_cnt_inc;
    logic [5:0]  w_b1, w_b2, w_b3;
    logic [10:0] w_cp2;
    logic [15:0] w_cp3;
    logic [20:0] w_cp4;
    logic [20:0] w_cp4_off;
    t_job        w_job;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;
    assign w_byte   = i_data.byte_value;
    assign w_last   = i_data.last_byte;

    // continuation test and sequence assembly
    assign w_cont    = (w_byte & CONT_MASK) == CONT_TAG;
    assign w_need    = lead_len(r_held_bytes[7:0]);
    assign w_cnt_inc = {1'b0, r_held_count} + 3'd1;
    assign w_b1      = (r_held_count == 2'd1) ? w_byte[5:0] : r_held_bytes[13:8];
    assign w_b2      = (r_held_count == 2'd2) ? w_byte[5:0] : r_held_bytes[21:16];
    assign w_b3      = w_byte[5:0];
    assign w_cp2     = {r_held_bytes[4:0], w_b1};
    assign w_cp3     = {r_held_bytes[3:0], w_b1, w_b2};
    assign w_cp4     = {r_held_bytes[2:0], w_b1, w_b2, w_b3};
    assign w_cp4_off = w_cp4 - SUPP_BASE;

    // classify the byte and build its job
    always_comb begin
        w_job        = '0;
        w_job.last   = w_last;
        n_held_bytes = r_held_bytes;
        n_held_count = r_held_count;
        if (r_held_count != 2'd0 && w_cont) begin
            if (w_need == 3'd0 || w_cnt_inc > w_need) begin
                w_job.repl_count = w_cnt_inc;
                n_held_bytes     = '0;
                n_held_count     = '0;
            end else if (w_cnt_inc == w_need) begin
                n_held_bytes = '0;
                n_held_count = '0;
                unique case (w_need)
                    3'd2: begin
                        if (w_cp2 < MIN_2BYTE) begin
                            w_job.repl_count = 3'd2;
                        end else begin
                            w_job.tail_count = 2'd1;
                            w_job.tail_first = {5'd0, w_cp2};
                        end
                    end
                    3'd3: begin
                        if (w_cp3 < MIN_3BYTE || (w_cp3 >= SURR_FIRST && w_cp3 <= SURR_LAST)) begin
                            w_job.repl_count = 3'd3;
                        end else begin
                            w_job.tail_count = 2'd1;
                            w_job.tail_first = w_cp3;
                        end
                    end
                    3'd4: begin
                        if (w_cp4 < SUPP_BASE || w_cp4 > CP_MAX) begin
                            w_job.repl_count = 3'd4;
                        end else begin
                            w_job.tail_count  = 2'd2;
                            w_job.tail_first  = HI_SURR_BASE + {6'd0, w_cp4_off[19:10]};
                            w_job.tail_second = LO_SURR_BASE + {6'd0, w_cp4_off[9:0]};
                        end
                    end
                    default: begin
                        w_job.repl_count = w_cnt_inc;
                    end
                endcase
            end else if (w_last) begin
                w_job.repl_count = w_cnt_inc;
                n_held_bytes     = '0;
                n_held_count     = '0;
            end else begin
                unique case (r_held_count)
                    2'd1:    n_held_bytes[15:8]  = w_byte;
                    2'd2:    n_held_bytes[23:16] = w_byte;
                    default: n_held_bytes        = r_held_bytes;
                endcase
                n_held_count = w_cnt_inc[1:0];
            end
        end else begin
            // flush a broken sequence, then decode the byte afresh
            w_job.repl_count = {1'b0, r_held_count};
            n_held_bytes     = '0;
            n_held_count     = '0;
            if (w_byte < ASCII_LIMIT) begin
                w_job.tail_count = 2'd1;
                w_job.tail_first = {8'd0, w_byte};
            end else if (lead_len(w_byte) == 3'd0 || w_last) begin
                w_job.repl_count = w_job.repl_count + 3'd1;
            end else begin
                n_held_bytes = {16'd0, w_byte};
                n_held_count = 2'd1;
            end
        end
    end

    assign o_job  = w_job;
    assign o_push = w_accept && (w_job.repl_count != 3'd0 || w_job.tail_count != 2'd0);

    // held sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= '0;
            r_held_count <= '0;
        end else if (w_accept) begin
            r_held_bytes <= n_held_bytes;
            r_held_count <= n_held_count;
        end
    end

endmodule

// ----- design/u8u16_queue.sv -----
module u8u16_queue #(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u8u16_pkg::t_job      i_job,
    input  logic                 i_pop,
    output u8u16_pkg::t_job      o_job,
    output u8u16_pkg::t_q_status o_status
);
    import u8u16_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_status.full  = r_count == CNT_W'(DEPTH);
    assign o_status.empty = r_count == '0;
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_job  = r_slots[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/u8u16_back.sv -----
module u8u16_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u8u16_pkg::t_job      i_job,
    input  u8u16_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output u8u16_pkg::t_out_beat o_data
);
    import u8u16_pkg::*;

    function automatic logic [2:0] w_job_total(input t_job job);
        return job.repl_count + {1'b0, job.tail_count};
    endfunction

    logic [1:0]  r_idx;
    logic        r_valid;
    t_out_beat   r_data;
    logic        w_load;
    logic [2:0]  w_total;
    logic [2:0]  w_pos;
    logic        w_final;
    logic [15:0] w_unit;

    // position within the head job
    assign w_total = w_job_total(i_job);
    assign w_pos   = {1'b0, r_idx};
    assign w_final = w_pos == (w_total - 3'd1);
    assign w_load  = !i_q_status.empty && (!r_valid || i_ready);
    assign o_pop   = w_load && w_final;

    // replacements go out first, then the decoded units
    always_comb begin
        if (w_pos < i_job.repl_count) begin
            w_unit = REPL_UNIT;
        end else if (w_pos == i_job.repl_count) begin
            w_unit = i_job.tail_first;
        end else begin
            w_unit = i_job.tail_second;
        end
    end

    // output register and unit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_final ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data.code_unit <= w_unit;
            r_data.last_unit <= i_job.last && w_final;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- design/utf8_to_utf16_transcoder.sv -----
// the units of a byte pass through the job queue, then the unit emitter's output register
// throughput: one byte per cycle in, one code unit per cycle out while i_ready is high; a byte may make up to
//   four units, and the input stalls once the job queue of QUEUE_DEPTH entries is full
// the output rate is set by the single output register of the unit emitter
// reset: synchronous active low; clears the held sequence, the job queue and output valid
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  u8u16_pkg::t_in_beat  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output u8u16_pkg::t_out_beat o_data
);
    import u8u16_pkg::*;

    logic      w_push, w_pop;
    t_job      w_push_job, w_head_job;
    t_q_status w_q_status;

    // byte decoder
    u8u16_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // job queue
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    // unit emitter
    u8u16_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_head_job),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

`ifndef SYNTHESIS
    // a job never goes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("job pushed into full queue");

    // the emitter never takes a job from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("job popped from empty queue");

    // a final byte always makes at least one unit
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.last_byte) |-> w_push)
        else $error("final byte produced no job");
`endif

endmodule

// ----- test/utf8_to_utf16_transcoder_test.sv -----
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_test;
    import u8u16_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    t_in_beat  byte_beat  = '0;
    logic      unit_valid;
    logic      unit_ready = 1'b0;
    t_out_beat unit_beat;

    // decoder state as the block should hold it
    logic [23:0] held_bits = '0;
    logic [1:0]  held_cnt  = '0;

    t_out_beat   units_due[$];
    t_out_beat   step_units[$];
    logic [7:0]  seq_bytes[$];

    bit idle_on     = 1'b1;
    int hold_left   = 0;
    int rx_stall    = 0;
    int failures    = 0;
    int sent_bytes  = 0;
    int cycle_count = 0;

    utf8_to_utf16_transcoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (byte_valid),
        .o_ready (byte_ready),
        .i_data  (byte_beat),
        .o_valid (unit_valid),
        .i_ready (unit_ready),
        .o_data  (unit_beat)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d units still due", cycle_count,
                     units_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // ---------------------------------------------------------------- prediction

    function automatic int seq_length(input logic [7:0] lead);
        if (lead[7:5] == 3'b110) return 2;
        if (lead[7:4] == 4'b1110) return 3;
        if (lead[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    function automatic void push_unit(input logic [15:0] unit);
        t_out_beat beat;
        beat.code_unit = unit;
        beat.last_unit = 1'b0;
        step_units.insert(step_units.size(), beat);
    endfunction

    function automatic void push_repl(input int times);
        for (int i = 0; i < times; i++) begin
            push_unit(REPL_UNIT);
        end
    endfunction

    // complete sequence: code point, or replacements when overlong, surrogate or too high
    function automatic void decode_complete(input logic [31:0] bits, input int len);
        logic [7:0]  b0;
        logic [5:0]  b1;
        logic [5:0]  b2;
        logic [5:0]  b3;
        logic [20:0] cp;
        b0 = bits[7:0];
        b1 = bits[13:8];
        b2 = bits[21:16];
        b3 = bits[29:24];
        if (len == 2) begin
            cp = {10'd0, b0[4:0], b1};
            if (cp < 21'h80) push_repl(2);
            else push_unit(cp[15:0]);
        end else if (len == 3) begin
            cp = {5'd0, b0[3:0], b1, b2};
            if (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF)) push_repl(3);
            else push_unit(cp[15:0]);
        end else begin
            cp = {b0[2:0], b1, b2, b3};
            if (cp < 21'h10000 || cp > 21'h10FFFF) begin
                push_repl(4);
            end else begin
                cp = cp - 21'h10000;
                push_unit(16'hD800 + {6'd0, cp[19:10]});
                push_unit(16'hDC00 + {6'd0, cp[9:0]});
            end
        end
    endfunction

    // units that one accepted byte makes final
    function automatic void predict_byte(input logic [7:0] value, input logic is_last);
        int          cnt;
        int          need;
        logic [31:0] bits;
        step_units.delete();
        cnt = held_cnt;
        if (cnt > 0 && value[7:6] == 2'b10) begin
            need = seq_length(held_bits[7:0]);
            bits = {8'd0, held_bits} | ({24'd0, value} << (8 * cnt));
            if (need == 0 || cnt + 1 > need) begin
                held_bits = '0;
                held_cnt  = '0;
                push_repl(cnt + 1);
            end else if (cnt + 1 == need) begin
                held_bits = '0;
                held_cnt  = '0;
                decode_complete(bits, need);
            end else if (is_last) begin
                held_bits = '0;
                held_cnt  = '0;
                push_repl(cnt + 1);
            end else begin
                held_bits = bits[23:0];
                held_cnt  = 2'(cnt + 1);
            end
        end else begin
            // broken sequence: replace what is held, then take the byte afresh
            if (cnt > 0) begin
                push_repl(cnt);
                held_bits = '0;
                held_cnt  = '0;
            end
            if (value < 8'h80) begin
                push_unit({8'd0, value});
            end else if (seq_length(value) == 0 || is_last) begin
                push_repl(1);
            end else begin
                held_bits = {16'd0, value};
                held_cnt  = 2'd1;
            end
        end
        if (is_last && step_units.size() > 0) begin
            step_units[step_units.size() - 1].last_unit = 1'b1;
        end
        foreach (step_units[i]) begin
            units_due.insert(units_due.size(), step_units[i]);
        end
    endfunction

    // ---------------------------------------------------------------- output side

    // receiver: long hold-off first, then the per-beat stall
    always @(negedge clk) begin
        if (!rst_n) begin
            unit_ready <= 1'b0;
        end else if (hold_left > 0) begin
            unit_ready <= 1'b0;
            hold_left--;
        end else if (rx_stall > 0) begin
            unit_ready <= 1'b0;
            rx_stall--;
        end else begin
            unit_ready <= 1'b1;
        end
    end

    // compare each output beat with the oldest expected unit
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && unit_valid && unit_ready) begin
            if (units_due.size() == 0) begin
                note_failure($sformatf("unexpected unit %h last %b",
                                       unit_beat.code_unit, unit_beat.last_unit));
            end else begin
                want = units_due.pop_front();
                if (unit_beat.code_unit !== want.code_unit
                        || unit_beat.last_unit !== want.last_unit) begin
                    note_failure($sformatf("unit mismatch: expected %h last %b, got %h last %b",
                                           want.code_unit, want.last_unit,
                                           unit_beat.code_unit, unit_beat.last_unit));
                end
            end
            rx_stall = idle_on ? $urandom_range(0, 15) : 0;
        end
    end

    // ---------------------------------------------------------------- input side

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int       gap;
        t_in_beat beat;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        beat.byte_value = value;
        beat.last_byte  = is_last;
        repeat (gap) begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_beat  <= beat;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        predict_byte(value, is_last);
        sent_bytes++;
    endtask

    // append one byte to the pending sequence
    function automatic void add_seq_byte(input logic [7:0] value);
        seq_bytes.insert(seq_bytes.size(), value);
    endfunction

    // send the queued bytes, flagging the final one as end of string if asked
    task automatic send_seq(input logic end_of_string);
        int n;
        n = seq_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(seq_bytes[i], end_of_string && (i == n - 1));
        end
        seq_bytes.delete();
    endtask

    function automatic logic [7:0] rand_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic void queue_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_seq_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_seq_byte({3'b110, cp[10:6]});
            add_seq_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_seq_byte({4'b1110, cp[15:12]});
            add_seq_byte({2'b10, cp[11:6]});
            add_seq_byte({2'b10, cp[5:0]});
        end else begin
            add_seq_byte({5'b11110, cp[20:18]});
            add_seq_byte({2'b10, cp[17:12]});
            add_seq_byte({2'b10, cp[11:6]});
            add_seq_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] rand_code_point();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(0, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2: begin
                // skip the surrogate block
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= 21'hD800) cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // complete sequence that must be replaced: overlong, surrogate or above range
    function automatic void queue_bad_complete();
        case ($urandom_range(0, 5))
            0: begin
                add_seq_byte({7'b1100000, 1'($urandom_range(0, 1))});
                add_seq_byte(rand_cont());
            end
            1: begin
                add_seq_byte(8'hE0);
                add_seq_byte(8'($urandom_range('h80, 'h9F)));
                add_seq_byte(rand_cont());
            end
            2: begin
                add_seq_byte(8'hF0);
                add_seq_byte(8'($urandom_range('h80, 'h8F)));
                add_seq_byte(rand_cont());
                add_seq_byte(rand_cont());
            end
            3: begin
                add_seq_byte(8'hED);
                add_seq_byte(8'($urandom_range('hA0, 'hBF)));
                add_seq_byte(rand_cont());
            end
            4: begin
                add_seq_byte(8'hF4);
                add_seq_byte(8'($urandom_range('h90, 'hBF)));
                add_seq_byte(rand_cont());
                add_seq_byte(rand_cont());
            end
            default: begin
                add_seq_byte(8'($urandom_range('hF5, 'hF7)));
                add_seq_byte(rand_cont());
                add_seq_byte(rand_cont());
                add_seq_byte(rand_cont());
            end
        endcase
    endfunction

    // lead plus too few continuations, cut by end of string or a fresh byte
    task automatic send_broken();
        int         len;
        int         conts;
        logic [7:0] breaker;
        len = $urandom_range(2, 4);
        case (len)
            2:       add_seq_byte({3'b110, 5'($urandom_range(0, 31))});
            3:       add_seq_byte({4'b1110, 4'($urandom_range(0, 15))});
            default: add_seq_byte({5'b11110, 3'($urandom_range(0, 7))});
        endcase
        conts = $urandom_range(0, len - 2);
        repeat (conts) add_seq_byte(rand_cont());
        if ($urandom_range(0, 1) == 0) begin
            send_seq(1'b1);
        end else begin
            breaker = 8'($urandom_range(0, 255));
            if (breaker[7:6] == 2'b10) breaker[6] = 1'b1;
            add_seq_byte(breaker);
            send_seq($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (units_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_well_formed();
        idle_on = 1'b1;
        seq_bytes = '{8'h00, 8'h7F};
        send_seq(1'b1);
        seq_bytes = '{8'hC2, 8'h80};
        send_seq(1'b0);
        seq_bytes = '{8'hEF, 8'hBF, 8'hBF};
        send_seq(1'b0);
        // highest code point, as a surrogate pair
        seq_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_seq(1'b1);
    endtask

    task automatic test_bad_input();
        // stray continuation, then invalid lead
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // overlong two-byte form
        seq_bytes = '{8'hC0, 8'hAF};
        send_seq(1'b0);
        // surrogate
        seq_bytes = '{8'hED, 8'hA0, 8'h80};
        send_seq(1'b0);
        // above the top of the code space, four replacements with last on the final one
        seq_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_seq(1'b1);
        // sequence broken by plain ascii
        seq_bytes = '{8'hE2, 8'h41};
        send_seq(1'b0);
        // string ends inside a sequence
        seq_bytes = '{8'hE2, 8'h82};
        send_seq(1'b1);
    endtask

    task automatic run_random(input int target);
        int stop_at;
        int n;
        stop_at = sent_bytes + target;
        while (sent_bytes < stop_at) begin
            n = $urandom_range(0, 9);
            if (n <= 5) begin
                repeat ($urandom_range(1, 3)) queue_code_point(rand_code_point());
                send_seq($urandom_range(0, 3) == 0);
            end else if (n == 6) begin
                queue_bad_complete();
                send_seq($urandom_range(0, 3) == 0);
            end else if (n == 7) begin
                send_broken();
            end else if (n == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            end else begin
                repeat ($urandom_range(1, 3)) add_seq_byte(rand_cont());
                send_seq($urandom_range(0, 1) == 0);
            end
        end
    endtask

    task automatic test_random_idle();
        idle_on = 1'b1;
        run_random(40);
    endtask

    task automatic test_random_burst();
        idle_on = 1'b0;
        run_random(30);
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        int stop_at;
        idle_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        stop_at   = sent_bytes + 40;
        while (sent_bytes < stop_at) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_code_point(21'($urandom_range('h10000, 'h10FFFF)));
            end else begin
                seq_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
                seq_bytes[1] = 8'($urandom_range('h90, 'hBF));
            end
            send_seq($urandom_range(0, 3) == 0);
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_well_formed();
        test_bad_input();
        test_random_idle();
        test_random_burst();
        test_backpressure();
        test_random_idle();
        wait_drained();
        if (units_due.size() != 0) begin
            note_failure($sformatf("%0d expected units never arrived", units_due.size()));
        end
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/u8u16_pkg.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/utf8_to_utf16_transcoder.sv
test/utf8_to_utf16_transcoder_test.sv
